// ----- rtl/emt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_pkg
// Shared types and codes for the extent map block translator.
// ----------------------------------------------------------------------------
package emt_pkg;

    localparam int MAP_WORDS_DEF = 256;

    localparam int WORD_W = 16;
    localparam int VBN_W  = 32;
    localparam int LBN_W  = 33;
    localparam int BLK_W  = 40;
    localparam int P_W    = 9;
    localparam int CNT_W  = 31;
    localparam int WIU_W  = 8;

    // result status codes
    localparam logic [1:0] ST_MAPPED     = 2'd0;
    localparam logic [1:0] ST_PAST_END   = 2'd1;
    localparam logic [1:0] ST_ZERO_BLOCK = 2'd2;
    localparam logic [1:0] ST_LOAD_DONE  = 2'd3;

    // request actions
    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // retrieval pointer formats (top two bits of the first word)
    localparam logic [1:0] FMT_NONE  = 2'd0;
    localparam logic [1:0] FMT_SHORT = 2'd1;
    localparam logic [1:0] FMT_MID   = 2'd2;
    localparam logic [1:0] FMT_LONG  = 2'd3;

    typedef struct packed {
        logic              action;
        logic [7:0]        word_index;
        logic [WORD_W-1:0] map_word;
        logic [VBN_W-1:0]  vbn;
    } emt_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [LBN_W-1:0] lbn;
    } emt_out_t;

    typedef struct packed {
        logic       accept_item;
        logic       map_write;
        logic       rd_issue;
        logic       capture;
        logic [1:0] word_sel;
        logic       add_count;
        logic       advance;
        logic       resolve;
        logic       form_lbn;
        logic       out_write;
        logic [1:0] kind;
    } emt_cmd_t;

    typedef struct packed {
        logic       walk_open;
        logic [1:0] rd_fmt;
        logic [1:0] w0_fmt;
        logic       hit;
        logic       before_blk;
        logic       out_free;
    } emt_stat_t;

endpackage

// ----- rtl/emt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/emt_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_dpath
// Map store, walk registers, pointer decode, lbn forming and result register.
// ----------------------------------------------------------------------------
module emt_dpath #(
    parameter int MAP_WORDS = emt_pkg::MAP_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  emt_pkg::emt_in_t  in_data,
    input  logic              cfg_write_enable,
    input  logic [7:0]        cfg_write_data,
    input  logic              out_stall,
    input  emt_pkg::emt_cmd_t cmd,
    output emt_pkg::emt_stat_t stat,
    output logic              out_valid,
    output emt_pkg::emt_out_t out_data
);
    import emt_pkg::*;

    localparam int AW = $clog2(MAP_WORDS);

    logic [MAP_WORDS-1:0] valid_reg;
    logic [WIU_W-1:0]     wiu_reg;
    logic [VBN_W-1:0]     vbn_reg;
    logic [P_W-1:0]       p_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [BLK_W-1:0]     sum_reg;
    logic [WORD_W-1:0]    w_reg [4];
    logic [VBN_W-1:0]     diff_reg;
    logic [LBN_W-1:0]     lbn_reg;
    logic                 rd_ok_reg;
    logic                 out_valid_reg;
    emt_out_t             out_data_reg;

    logic [P_W-1:0]       rd_addr;
    logic                 rd_in_range;
    logic                 wr_in_range;
    logic                 map_we;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    w0;
    logic [CNT_W-1:0]     cnt;
    logic [VBN_W-1:0]     base;
    logic [1:0]           final_status;

    assign rd_addr     = p_reg + P_W'(cmd.word_sel);
    assign rd_in_range = rd_addr < P_W'(MAP_WORDS);
    assign wr_in_range = {1'b0, in_data.word_index} < P_W'(MAP_WORDS);
    assign map_we      = cmd.map_write && wr_in_range;

    emt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (in_data.word_index[AW-1:0]),
        .wdata (in_data.map_word),
        .re    (cmd.rd_issue),
        .raddr (rd_addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // never-written words and words past the store read as zero
    assign rd_word = rd_ok_reg ? ram_rdata : '0;
    assign w0      = w_reg[0];

    always_comb
    begin
        unique case (w0[15:14])
            FMT_NONE:
            begin
                cnt  = '0;
                base = '0;
            end
            FMT_SHORT:
            begin
                cnt  = CNT_W'(w0[7:0]) + CNT_W'(1);
                base = {10'd0, w0[13:8], w_reg[1]};
            end
            FMT_MID:
            begin
                cnt  = CNT_W'(w0[13:0]) + CNT_W'(1);
                base = {w_reg[2], w_reg[1]};
            end
            default:
            begin
                cnt  = CNT_W'({w0[13:0], w_reg[1]}) + CNT_W'(1);
                base = {w_reg[3], w_reg[2]};
            end
        endcase
    end

    always_comb
    begin
        if (cmd.kind == ST_MAPPED && lbn_reg == '0)
        begin
            final_status = ST_ZERO_BLOCK;
        end
        else
        begin
            final_status = cmd.kind;
        end
    end

    assign stat.walk_open  = p_reg < P_W'(wiu_reg);
    assign stat.rd_fmt     = rd_word[15:14];
    assign stat.w0_fmt     = w0[15:14];
    assign stat.hit        = BLK_W'(vbn_reg) < sum_reg;
    assign stat.before_blk = BLK_W'(vbn_reg) < blk_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wiu_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (map_we)
            begin
                valid_reg[in_data.word_index[AW-1:0]] <= 1'b1;
            end
            if (cfg_write_enable)
            begin
                wiu_reg <= cfg_write_data;
            end
            if (cmd.out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_item)
        begin
            vbn_reg <= in_data.vbn;
            p_reg   <= '0;
            blk_reg <= BLK_W'(1);
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= rd_in_range && valid_reg[rd_addr[AW-1:0]];
        end
        if (cmd.capture)
        begin
            w_reg[cmd.word_sel] <= rd_word;
        end
        if (cmd.add_count)
        begin
            sum_reg <= blk_reg + BLK_W'(cnt);
        end
        if (cmd.advance)
        begin
            blk_reg <= sum_reg;
            p_reg   <= p_reg + P_W'(w0[15:14]) + P_W'(1);
        end
        if (cmd.resolve)
        begin
            // diff is used only when vbn is at or above blk, so the low word is enough
            diff_reg <= vbn_reg - blk_reg[VBN_W-1:0];
        end
        if (cmd.form_lbn)
        begin
            lbn_reg <= LBN_W'(base) + LBN_W'(diff_reg);
        end
        if (cmd.out_write)
        begin
            out_data_reg.status <= final_status;
            out_data_reg.lbn    <= (final_status == ST_MAPPED) ? lbn_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/emt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_ctrl
// Sequencer for loads and for the retrieval pointer walk.
// ----------------------------------------------------------------------------
module emt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_action,
    output logic               in_stall,
    input  emt_pkg::emt_stat_t stat,
    output emt_pkg::emt_cmd_t  cmd
);
    import emt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_READ    = 4'd2;
    localparam logic [3:0] S_CAPT    = 4'd3;
    localparam logic [3:0] S_ADD     = 4'd4;
    localparam logic [3:0] S_CMP     = 4'd5;
    localparam logic [3:0] S_RESOLVE = 4'd6;
    localparam logic [3:0] S_FORM    = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] cur_fmt;

    // pointer length minus one equals its format code
    assign cur_fmt = (k_reg == 2'd0) ? stat.rd_fmt : stat.w0_fmt;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.word_sel = k_reg;
        cmd.kind     = kind_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept_item = 1'b1;
                    if (in_action == ACT_LOAD)
                    begin
                        cmd.map_write = 1'b1;
                        kind_next     = ST_LOAD_DONE;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                k_next = 2'd0;
                if (stat.walk_open)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    kind_next  = ST_PAST_END;
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_CAPT;
            end
            S_CAPT:
            begin
                cmd.capture = 1'b1;
                if (cur_fmt > k_reg)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_count = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP:
            begin
                if (stat.hit)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                if (stat.before_blk)
                begin
                    // block number below the first mapped block
                    kind_next  = ST_PAST_END;
                    state_next = S_FINISH;
                end
                else
                begin
                    kind_next  = ST_MAPPED;
                    state_next = S_FORM;
                end
            end
            S_FORM:
            begin
                cmd.form_lbn = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 2'd0;
            kind_reg  <= ST_LOAD_DONE;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- rtl/extent_map_block_translator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_map_block_translator_unit
// Loads an extent map word by word and translates virtual to logical blocks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid / in_stall         | in_data (emt_in_t)
//  out     | output    | out_valid / out_stall       | out_data (emt_out_t)
//  cfg     | input     | cfg_write_enable            | cfg_write_data (words in use)
//
// A load writes its word and then posts a result. A translate walks W map words
// in P pointers, limited by the single read port of the map RAM (each word is
// read and then captured) and the add/compare step per pointer.
// Reset clears the map through per-word valid bits; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// request is taken meanwhile and holds in its final step until the slot frees.
module extent_map_block_translator_unit #(
    parameter int MAP_WORDS = emt_pkg::MAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  emt_pkg::emt_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output emt_pkg::emt_out_t out_data,
    input  logic             cfg_write_enable,
    input  logic [7:0]       cfg_write_data
);
    import emt_pkg::*;

    emt_cmd_t  cmd;
    emt_stat_t stat;

    emt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    emt_dpath #(
        .MAP_WORDS (MAP_WORDS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_data          (in_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_stall        (out_stall),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_data         (out_data)
    );

endmodule
